// ===== rtl/core/ecpq_pkg.sv =====
// Package for the event calendar priority queue core.
// Types, codes and constants shared by the front, back and top level.
package ecpq_pkg;

  localparam int DefaultDepth = 16;
  localparam int TimeW = 48;
  localparam int LatW  = 32;
  localparam int OccW  = 5;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_CLONE    = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_DISPATCHED = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_FULL       = 3'd3,
    ST_NO_CURRENT = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] latency;
    logic [7:0]  priority_req;
    logic [3:0]  device_id;
    logic [2:0]  op_kind;
    logic [47:0] address;
    logic [15:0] access_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] event_time;
    logic [7:0]  out_priority;
    logic [3:0]  out_device;
    logic [2:0]  out_op;
    logic [47:0] out_address;
    logic [15:0] out_size;
    logic [4:0]  occupancy;
  } out_item_t;

  // One calendar entry.
  typedef struct packed {
    logic [47:0] time_due;
    logic [7:0]  prio;
    logic [3:0]  dev;
    logic [2:0]  op;
    logic [47:0] addr;
    logic [15:0] size;
  } cal_entry_t;

  // Item handed from front to back.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] latency;
    cal_entry_t  ent;
  } cmd_t;

endpackage

// ===== rtl/core/event_calendar_priority_queue_core.sv =====
// Top level of the event calendar priority queue core.
// Depends on ecpq_pkg, ecpq_front and ecpq_back.
//
// Usage:
//  - Input channel is a queue: drive in_item and raise in_push while
//    in_full is low; an item is taken on that edge.
//  - Result channel is a queue: while out_empty is low, out_item holds the
//    oldest result; raise out_pop to take it. One result per item.
//  - Commands: insert (due = now + latency, saturating), dispatch the
//    earliest event (time, then priority, then arrival order), clone the
//    current event at priority 0 with a new device.
//  - Flow: an accepted item waits in the front FIFO; the edge that takes
//    it updates the calendar and writes the result FIFO.
//  - Throughput: one item per cycle while the result FIFO has room; the
//    sorted cell row is updated at once by a compare in every cell.
//  - Stall: a held result fills the two-entry result FIFO, then the back
//    stops draining the two-entry front FIFO and in_full rises.
//  - Reset: synchronous, active low; empties both FIFOs and the calendar,
//    sets current time to zero and clears the current event.
module event_calendar_priority_queue_core
  import ecpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DefaultDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic avail, take;
  cmd_t cmd;

  ecpq_front u_front (
    .clk, .rst_n, .push(in_push), .item(in_item), .full(in_full),
    .take, .avail, .cmd
  );

  ecpq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst_n, .avail, .cmd, .take,
    .res_empty(out_empty), .pop(out_pop), .res(out_item)
  );

  // Occupancy never exceeds depth (when it fits the field).
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && QUEUE_DEPTH < 32) |-> (int'(out_item.occupancy) <= QUEUE_DEPTH))
    else $error("occupancy above depth");

  // A taken dispatch always yields a dispatched or empty status.
  a_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cmd.opcode == OP_DISPATCH) |->
      (u_back.r.status == ST_DISPATCHED || u_back.r.status == ST_EMPTY))
    else $error("dispatch status");

endmodule

// ===== rtl/core/ecpq_front.sv =====
// Front: input queue of decoded commands (small FIFO).
// Depends on ecpq_pkg.
module ecpq_front
  import ecpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t item,
  output logic     full,
  input  logic     take,
  output logic     avail,
  output cmd_t     cmd
);

  cmd_t       buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       dec;

  always_comb begin
    dec.opcode       = item.opcode;
    dec.latency      = item.latency;
    dec.ent.time_due = '0;
    dec.ent.prio     = item.priority_req;
    dec.ent.dev      = item.device_id;
    dec.ent.op       = item.op_kind;
    dec.ent.addr     = item.address;
    dec.ent.size     = item.access_size;
  end

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign cmd   = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) buf_r[wp_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (take && avail) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(take && avail);
    end
  end

endmodule

// ===== rtl/core/ecpq_back.sv =====
// Back: shift-register sorted calendar, current event, result FIFO.
// Depends on ecpq_pkg.
module ecpq_back
  import ecpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DefaultDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      avail,
  input  cmd_t      cmd,
  output logic      take,
  output logic      res_empty,
  input  logic      pop,
  output out_item_t res
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cal_entry_t cell_r [QUEUE_DEPTH];
  logic [CntW-1:0] cnt_r;
  logic [TimeW-1:0] now_r;
  logic cur_v_r;
  cal_entry_t cur_r;

  out_item_t obuf_r [2];
  logic owp_r, orp_r;
  logic [1:0] ocnt_r;

  logic [TimeW:0] sum;
  logic [TimeW-1:0] due;
  cal_entry_t newe;
  logic [QUEUE_DEPTH-1:0] gt;
  logic do_ins, do_deq;
  out_item_t r;
  logic [CntW-1:0] cnt_nxt;

  assign take = avail && (ocnt_r != 2'd2);

  always_comb begin
    sum = {1'b0, now_r} + {{(TimeW-LatW+1){1'b0}}, cmd.latency};
    due = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
    newe = cmd.ent;
    if (cmd.opcode == OP_CLONE) begin
      newe = cur_r;
      newe.prio = '0;
      newe.dev = cmd.ent.dev;
    end
    newe.time_due = due;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      gt[i] = (CntW'(i) < cnt_r) &&
              ((cell_r[i].time_due > due) ||
               (cell_r[i].time_due == due && cell_r[i].prio > newe.prio));
    end
    do_ins = 1'b0; do_deq = 1'b0;
    cnt_nxt = cnt_r;
    r = '0;
    case (opcode_t'(cmd.opcode))
      OP_INSERT, OP_CLONE: begin
        if (cmd.opcode == OP_CLONE && !cur_v_r) r.status = ST_NO_CURRENT;
        else if (cnt_r == CntW'(QUEUE_DEPTH)) r.status = ST_FULL;
        else begin
          do_ins = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          r.status = ST_INSERTED;
          r.event_time = newe.time_due; r.out_priority = newe.prio;
          r.out_device = newe.dev; r.out_op = newe.op;
          r.out_address = newe.addr; r.out_size = newe.size;
        end
      end
      OP_DISPATCH: begin
        if (cnt_r == '0) r.status = ST_EMPTY;
        else begin
          do_deq = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
          r.status = ST_DISPATCHED;
          r.event_time = cell_r[0].time_due; r.out_priority = cell_r[0].prio;
          r.out_device = cell_r[0].dev; r.out_op = cell_r[0].op;
          r.out_address = cell_r[0].addr; r.out_size = cell_r[0].size;
        end
      end
      default: r.status = ST_NO_CURRENT;
    endcase
    r.occupancy = OccW'(cnt_nxt);
  end

  // Cells: on insert each cell keeps, takes the new entry, or takes its left neighbor.
  always_ff @(posedge clk) begin
    if (take && do_ins) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (gt[i]) cell_r[i] <= (i == 0) ? newe : (gt[(i == 0) ? 0 : i-1]
                               ? cell_r[(i == 0) ? 0 : i-1] : newe);
        else if (CntW'(i) == cnt_r) cell_r[i] <= (i == 0) ? newe :
                               (gt[(i == 0) ? 0 : i-1] ? cell_r[(i == 0) ? 0 : i-1] : newe);
      end
    end else if (take && do_deq) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) cell_r[i] <= cell_r[i+1];
    end
    if (take && do_deq) cur_r <= cell_r[0];
    if (take && ocnt_r != 2'd2) obuf_r[owp_r] <= r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; now_r <= '0; cur_v_r <= 1'b0;
      owp_r <= 1'b0; orp_r <= 1'b0; ocnt_r <= 2'd0;
    end else begin
      if (take) begin
        cnt_r <= cnt_nxt;
        owp_r <= ~owp_r;
      end
      if (take && do_deq) begin
        now_r <= cell_r[0].time_due;
        cur_v_r <= 1'b1;
      end
      if (pop && !res_empty) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + 2'(take) - 2'(pop && !res_empty);
    end
  end

  assign res_empty = (ocnt_r == 2'd0);
  assign res = obuf_r[orp_r];

endmodule
